@@ rtl/sorted_min_priority_queue_macros.svh @@
// Assertion macros for the sorted minimum-first priority queue.
// Included by files that carry concurrent assertions; no other dependencies.
`ifndef SORTED_MIN_PRIORITY_QUEUE_MACROS_SVH
`define SORTED_MIN_PRIORITY_QUEUE_MACROS_SVH

`ifndef ASSERT_OFF
`define SMPQ_ASSERT_ALWAYS(lbl, clk, rst, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);
`define SMPQ_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`else
`define SMPQ_ASSERT_ALWAYS(lbl, clk, rst, cond, msg)
`define SMPQ_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg)
`endif

`endif

@@ rtl/smpq_pkg.sv @@
// Shared types and constants of the sorted minimum-first priority queue.
// No dependencies; used by smpq_cell and sorted_min_priority_queue.
package smpq_pkg;

  localparam int CAPACITY    = 16;
  localparam int DATA_WIDTH  = 32;
  localparam int FIELD_WIDTH = 32;
  localparam int COUNT_WIDTH = 5;

  localparam logic OP_PUSH = 1'b0;
  localparam logic OP_POP  = 1'b1;

  typedef struct packed {
    logic                          opcode;
    logic signed [FIELD_WIDTH-1:0] push_value;
  } in_item_t;

  typedef struct packed {
    logic signed [FIELD_WIDTH-1:0] top_value;
    logic                          is_empty;
    logic [COUNT_WIDTH-1:0]        entry_count;
    logic                          push_dropped;
  } out_item_t;

  // Broadcast to every cell of the chain.
  typedef struct packed {
    logic push;
    logic pop;
  } cell_ctrl_t;

endpackage

@@ rtl/smpq_cell.sv @@
// One cell of the sorted chain: holds a single entry and shifts with its neighbors.
// Depends on smpq_pkg for the control struct.
module smpq_cell #(
  parameter int INDEX      = 0,
  parameter int DATA_WIDTH = smpq_pkg::DATA_WIDTH,
  parameter int OCC_WIDTH  = 5
) (
  input  logic                         clk,
  input  smpq_pkg::cell_ctrl_t         ctrl,
  input  logic signed [DATA_WIDTH-1:0] key,
  input  logic [OCC_WIDTH-1:0]         occupancy,
  input  logic                         left_le,
  input  logic signed [DATA_WIDTH-1:0] left_entry,
  input  logic signed [DATA_WIDTH-1:0] right_entry,
  output logic                         le,
  output logic signed [DATA_WIDTH-1:0] entry,
  output logic signed [DATA_WIDTH-1:0] entry_next
);

  logic occupied;

  assign occupied = occupancy > OCC_WIDTH'(INDEX);

  // Entries are ascending, so le is a run of ones followed by zeros; the
  // first cell whose le is low takes the key and the ones after it shift right.
  assign le = occupied && (entry <= key);

  always_comb begin
    entry_next = entry;
    if (ctrl.push) begin
      if (!le) begin
        entry_next = left_le ? key : left_entry;
      end
    end else if (ctrl.pop) begin
      entry_next = right_entry;
    end
  end

  always_ff @(posedge clk) begin
    entry <= entry_next;
  end

endmodule

@@ rtl/sorted_min_priority_queue.sv @@
// Sorted minimum-first priority queue built as a chain of entry cells.
// Cells compare and shift in the same cycle; results are registered the cycle after.
// Throughput: 1 item per cycle while out_ready takes any pending result.
// Reset: rst (synchronous) empties the queue and drops any pending result;
// entry contents are left as they are. Depends on smpq_pkg, smpq_cell and the macros.
`include "sorted_min_priority_queue_macros.svh"

module sorted_min_priority_queue #(
  parameter int CAPACITY   = smpq_pkg::CAPACITY,
  parameter int DATA_WIDTH = smpq_pkg::DATA_WIDTH
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  smpq_pkg::in_item_t  in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output smpq_pkg::out_item_t out_data
);

  localparam int OCC_WIDTH = $clog2(CAPACITY + 1);

  logic                         accept;
  logic                         is_full;
  logic                         push_ok;
  logic                         pop_ok;
  logic [OCC_WIDTH-1:0]         occupancy;
  logic [OCC_WIDTH-1:0]         occupancy_next;
  logic signed [DATA_WIDTH-1:0] key;
  smpq_pkg::cell_ctrl_t         ctrl;
  logic [CAPACITY-1:0]          le;
  logic signed [DATA_WIDTH-1:0] entry      [CAPACITY];
  logic signed [DATA_WIDTH-1:0] entry_next [CAPACITY];
  smpq_pkg::out_item_t          out_next;

  assign in_ready = !out_valid || out_ready;
  assign accept   = in_valid && in_ready;
  assign is_full  = occupancy >= OCC_WIDTH'(CAPACITY);
  assign push_ok  = accept && (in_data.opcode == smpq_pkg::OP_PUSH) && !is_full;
  assign pop_ok   = accept && (in_data.opcode == smpq_pkg::OP_POP) && (occupancy != '0);
  assign key      = DATA_WIDTH'(in_data.push_value);

  assign ctrl.push = push_ok;
  assign ctrl.pop  = pop_ok;

  always_comb begin
    occupancy_next = occupancy;
    if (push_ok) begin
      occupancy_next = occupancy + OCC_WIDTH'(1);
    end else if (pop_ok) begin
      occupancy_next = occupancy - OCC_WIDTH'(1);
    end
  end

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic                         left_le;
    logic signed [DATA_WIDTH-1:0] left_entry;
    logic signed [DATA_WIDTH-1:0] right_entry;

    if (i == 0) begin : g_head
      assign left_le    = 1'b1;
      assign left_entry = key;
    end else begin : g_body
      assign left_le    = le[i-1];
      assign left_entry = entry[i-1];
    end

    if (i == CAPACITY - 1) begin : g_tail
      assign right_entry = entry[i];
    end else begin : g_inner
      assign right_entry = entry[i+1];
    end

    smpq_cell #(
      .INDEX      (i),
      .DATA_WIDTH (DATA_WIDTH),
      .OCC_WIDTH  (OCC_WIDTH)
    ) u_cell (
      .clk         (clk),
      .ctrl        (ctrl),
      .key         (key),
      .occupancy   (occupancy),
      .left_le     (left_le),
      .left_entry  (left_entry),
      .right_entry (right_entry),
      .le          (le[i]),
      .entry       (entry[i]),
      .entry_next  (entry_next[i])
    );
  end

  always_comb begin
    out_next.is_empty     = occupancy_next == '0;
    out_next.top_value    = out_next.is_empty ? '0 : smpq_pkg::FIELD_WIDTH'(entry_next[0]);
    out_next.entry_count  = smpq_pkg::COUNT_WIDTH'(occupancy_next);
    out_next.push_dropped = (in_data.opcode == smpq_pkg::OP_PUSH) && is_full;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      occupancy <= '0;
      out_valid <= 1'b0;
    end else begin
      occupancy <= occupancy_next;
      if (accept) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      out_data <= out_next;
    end
  end

  `SMPQ_ASSERT_ALWAYS(a_occ_bound, clk, rst, occupancy <= OCC_WIDTH'(CAPACITY),
                      "occupancy above capacity")
  `SMPQ_ASSERT_ALWAYS(a_head_sorted, clk, rst,
                      (occupancy < OCC_WIDTH'(2)) || (entry[0] <= entry[1]),
                      "head entries out of order")
  `SMPQ_ASSERT_NEXT(a_full_drop, clk, rst,
                    accept && (in_data.opcode == smpq_pkg::OP_PUSH) && is_full,
                    out_data.push_dropped && $stable(occupancy),
                    "push to full queue not dropped")
  `SMPQ_ASSERT_NEXT(a_pop_count, clk, rst, pop_ok,
                    occupancy == $past(occupancy) - OCC_WIDTH'(1),
                    "pop did not remove one entry")

endmodule

@@ dv/testbench.sv @@
`timescale 1ns / 100ps
// Testbench for the sorted minimum-first priority queue: directed and random push/pop
// traffic with a shadow sorted list that predicts every result. Depends on smpq_pkg.
module testbench;

  typedef logic signed [smpq_pkg::FIELD_WIDTH-1:0] value_t;

  typedef struct {
    smpq_pkg::in_item_t op;
    bit                 drain_first;
  } stim_t;

  typedef enum {MIX_FILL, MIX_DRAIN, MIX_EVEN, MIX_DUPLICATES} mix_e;
  typedef enum {READY_ALWAYS, READY_RANDOM, READY_PERIODIC, READY_SPARSE} ready_mode_e;

  localparam value_t VALUE_MIN  = {1'b1, {(smpq_pkg::FIELD_WIDTH-1){1'b0}}};
  localparam value_t VALUE_MAX  = {1'b0, {(smpq_pkg::FIELD_WIDTH-1){1'b1}}};
  localparam int     IDLE_LIMIT = 2000;
  localparam int     RANDOM_OPS = 1500;

  logic                clk;
  logic                rst       = 1'b1;
  logic                in_valid  = 1'b0;
  logic                in_ready;
  smpq_pkg::in_item_t  in_data   = '0;
  logic                out_valid;
  logic                out_ready = 1'b0;
  smpq_pkg::out_item_t out_data;

  stim_t               stimulus_ops[$];
  value_t              shadow_entries[$];
  smpq_pkg::out_item_t awaited_results[$];

  int items_accepted  = 0;
  int results_checked = 0;
  int error_count     = 0;
  int idle_cycles     = 0;
  int push_total      = 0;
  int pop_total       = 0;
  int drop_total      = 0;
  int empty_pop_total = 0;
  int deepest         = 0;

  int          burst_left  = 0;
  int          gap_left    = 0;
  ready_mode_e ready_mode  = READY_ALWAYS;
  int          ready_timer = 0;
  int          ready_tick  = 0;

  sorted_min_priority_queue u_top (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Shadow of the queue: a new value goes after any stored equal values.
  function automatic smpq_pkg::out_item_t step_sorted_shadow(smpq_pkg::in_item_t op);
    smpq_pkg::out_item_t res;
    int                  slot;
    res = '0;
    if (op.opcode == smpq_pkg::OP_POP) begin
      pop_total++;
      if (shadow_entries.size() != 0) void'(shadow_entries.pop_front());
      else empty_pop_total++;
    end else if (shadow_entries.size() >= smpq_pkg::CAPACITY) begin
      res.push_dropped = 1'b1;
      drop_total++;
    end else begin
      slot = 0;
      while (slot < shadow_entries.size() && shadow_entries[slot] <= $signed(op.push_value))
        slot++;
      shadow_entries.insert(slot, op.push_value);
      push_total++;
    end
    if (shadow_entries.size() > deepest) deepest = shadow_entries.size();
    res.top_value   = (shadow_entries.size() != 0) ? shadow_entries[0] : '0;
    res.is_empty    = (shadow_entries.size() == 0);
    res.entry_count = smpq_pkg::COUNT_WIDTH'(shadow_entries.size());
    return res;
  endfunction

  function automatic value_t pick_value(bit narrow);
    value_t v;
    if (narrow) return value_t'($urandom_range(0, 6)) - 3;
    case ($urandom_range(0, 5))
      0:       v = VALUE_MIN + value_t'($urandom_range(0, 3));
      1:       v = VALUE_MAX - value_t'($urandom_range(0, 3));
      2:       v = value_t'($urandom_range(0, 8)) - 4;
      default: v = value_t'($urandom);
    endcase
    return v;
  endfunction

  function automatic stim_t make_op(logic opcode, value_t v, bit drain_first);
    stim_t s;
    s.op.opcode     = opcode;
    s.op.push_value = v;
    s.drain_first   = drain_first;
    return s;
  endfunction

  // Driver: bursts of random length separated by random gaps.
  always @(posedge clk) begin : drive_ops
    logic                next_valid;
    logic                took;
    smpq_pkg::out_item_t res;
    if (rst) begin
      in_valid   <= 1'b0;
      burst_left = 0;
      gap_left   = 0;
    end else begin
      took       = in_valid && in_ready;
      next_valid = in_valid;
      if (took) begin
        res = step_sorted_shadow(in_data);
        awaited_results.push_back(res);
        items_accepted <= items_accepted + 1;
        next_valid = 1'b0;
      end
      if (!next_valid && stimulus_ops.size() != 0) begin
        if (gap_left != 0) begin
          gap_left--;
        end else if (!stimulus_ops[0].drain_first ||
                     (!took && items_accepted == results_checked)) begin
          in_data <= stimulus_ops[0].op;
          void'(stimulus_ops.pop_front());
          next_valid = 1'b1;
          if (burst_left <= 1) begin
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(50, 200)
                                                     : $urandom_range(1, 12);
            gap_left   = $urandom_range(0, 5);
          end else begin
            burst_left--;
          end
        end
      end
      in_valid <= next_valid;
    end
  end

  // Monitor: checks each result against the oldest prediction and drives out_ready.
  always @(posedge clk) begin : check_results
    smpq_pkg::out_item_t want;
    logic                next_ready;
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        results_checked <= results_checked + 1;
        if (awaited_results.size() == 0) begin
          if (error_count < 10)
            $display("Unexpected result with nothing predicted: top %0d count %0d",
                     out_data.top_value, out_data.entry_count);
          error_count++;
        end else begin
          want = awaited_results.pop_front();
          if (out_data.top_value !== want.top_value || out_data.is_empty !== want.is_empty ||
              out_data.entry_count !== want.entry_count ||
              out_data.push_dropped !== want.push_dropped) begin
            if (error_count < 10) begin
              $display("Mismatch on result %0d: expected top %0d empty %0b count %0d dropped %0b",
                       results_checked, want.top_value, want.is_empty, want.entry_count,
                       want.push_dropped);
              $display("  got top %0d empty %0b count %0d dropped %0b",
                       out_data.top_value, out_data.is_empty, out_data.entry_count,
                       out_data.push_dropped);
            end
            error_count++;
          end
        end
      end
      if (ready_timer == 0) begin
        ready_mode  = ready_mode_e'($urandom_range(0, 3));
        ready_timer = $urandom_range(64, 256);
      end else begin
        ready_timer--;
      end
      ready_tick++;
      case (ready_mode)
        READY_ALWAYS:   next_ready = 1'b1;
        READY_RANDOM:   next_ready = ($urandom_range(0, 3) != 0);
        READY_PERIODIC: next_ready = ((ready_tick % 7) < 4);
        default:        next_ready = ($urandom_range(0, 5) == 0);
      endcase
      out_ready <= next_ready;
    end
  end

  always @(posedge clk) begin : watchdog
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("No transaction for %0d cycles, giving up", IDLE_LIMIT);
      $display("Verification failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin : run_test
    value_t fill_values[16];
    mix_e   mix;
    int     seg_len;
    int     seg_index;
    bit     narrow;
    logic   opcode;

    // Directed: pop on empty, extremes, duplicates, fill to full, pushes dropped when full.
    fill_values = '{VALUE_MAX, VALUE_MIN, 0, -1, 1, VALUE_MIN, VALUE_MAX, 32'sh5555_5555,
                    32'shAAAA_AAAA, 0, -1, VALUE_MIN + 1, VALUE_MAX - 1, 7, -7, 1};
    stimulus_ops.push_back(make_op(smpq_pkg::OP_POP, VALUE_MAX, 1'b0));
    foreach (fill_values[i])
      stimulus_ops.push_back(make_op(smpq_pkg::OP_PUSH, fill_values[i], 1'b0));
    stimulus_ops.push_back(make_op(smpq_pkg::OP_PUSH, VALUE_MIN, 1'b0));
    stimulus_ops.push_back(make_op(smpq_pkg::OP_PUSH, VALUE_MAX, 1'b0));
    repeat (3) stimulus_ops.push_back(make_op(smpq_pkg::OP_POP, 0, 1'b0));
    stimulus_ops.push_back(make_op(smpq_pkg::OP_PUSH, 1, 1'b0));

    // Random: segments that lean toward filling, draining, balance or duplicate values.
    // Every fourth segment waits for the queue of results to empty before it starts.
    seg_index = 0;
    while (stimulus_ops.size() < RANDOM_OPS + 22) begin
      mix     = mix_e'($urandom_range(0, 3));
      seg_len = $urandom_range(30, 120);
      narrow  = (mix == MIX_DUPLICATES);
      for (int k = 0; k < seg_len; k++) begin
        case (mix)
          MIX_FILL:  opcode = ($urandom_range(0, 99) < 15) ? smpq_pkg::OP_POP
                                                           : smpq_pkg::OP_PUSH;
          MIX_DRAIN: opcode = ($urandom_range(0, 99) < 80) ? smpq_pkg::OP_POP
                                                           : smpq_pkg::OP_PUSH;
          MIX_EVEN:  opcode = ($urandom_range(0, 1) == 0) ? smpq_pkg::OP_POP
                                                          : smpq_pkg::OP_PUSH;
          default:   opcode = ($urandom_range(0, 99) < 40) ? smpq_pkg::OP_POP
                                                           : smpq_pkg::OP_PUSH;
        endcase
        stimulus_ops.push_back(make_op(opcode, pick_value(narrow),
                                       (k == 0) && (seg_index % 4 == 0)));
      end
      seg_index++;
    end

    repeat (12) @(posedge clk);
    rst <= 1'b0;

    do @(posedge clk);
    while (stimulus_ops.size() != 0 || in_valid || awaited_results.size() != 0);
    repeat (8) @(posedge clk);

    if (awaited_results.size() != 0) begin
      $display("%0d predicted results never arrived", awaited_results.size());
      error_count++;
    end
    $display("Ran %0d transactions (%0d pushes stored, %0d pops), %0d results checked",
             items_accepted, push_total, pop_total, results_checked);
    $display("Saw %0d pushes dropped on a full queue, %0d pops on an empty queue",
             drop_total, empty_pop_total);
    $display("Queue depth reached %0d entries", deepest);
    if (error_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("%0d errors in total", error_count);
      $display("Verification failed");
    end
    $finish;
  end

endmodule
